@@ sv/cptt_pkg.sv @@
// shared constants and types of the child process tracking table
`default_nettype none

package cptt_pkg;

  localparam int ENTRIES = 16;
  localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int PID_W   = 16;
  localparam int OP_W    = 2;

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);

  localparam logic [OP_W-1:0] OP_ADD   = 2'd0;
  localparam logic [OP_W-1:0] OP_EXIT  = 2'd1;
  localparam logic [OP_W-1:0] OP_QUERY = 2'd2;

  // what a table scan is looking for
  typedef enum logic [2:0] {
    SCAN_FREE,     // first entry not live
    SCAN_CHILD,    // first live entry with matching child
    SCAN_LIVEPAR,  // any live entry of the exiting child's parent
    SCAN_PARENT,   // any entry naming the pid as parent
    SCAN_CLEAR     // every entry of that parent, cleared
  } scan_mode_t;

  typedef struct packed {
    logic       scan_start;
    scan_mode_t mode;
  } cptt_cmd_t;

  typedef struct packed {
    logic done;
    logic hit;
  } cptt_sts_t;

endpackage

`default_nettype wire

@@ sv/child_process_tracking_table_core.sv @@
// top level of the child process tracking table
// add and query each run a single scan before the result strobe
// exit runs up to three scans (child, live siblings, clear) before the result strobe
// throughput: one item at a time; each scan reads one memory entry per cycle, so the
//   single read port of the entry memory sets the rate; an unused op code runs no scan
// reset: synchronous active-low rst_n empties the table (valid and live bits cleared) at once
// the result strobe lasts one cycle and the receiver cannot stall it
`default_nettype none

module child_process_tracking_table_core (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  // command channel
  input  wire logic                       start,
  output logic                            busy,
  input  wire logic [cptt_pkg::OP_W-1:0]  in_op,
  input  wire logic [cptt_pkg::PID_W-1:0] in_parent_id,
  input  wire logic [cptt_pkg::PID_W-1:0] in_child_id,
  input  wire logic [cptt_pkg::PID_W-1:0] in_pid,
  // result channel, one transfer per item
  output logic                            out_valid,
  output logic                            out_add_done,
  output logic                            out_exit_found,
  output logic                            out_wake_valid,
  output logic [cptt_pkg::PID_W-1:0]      out_wake_pid,
  output logic                            out_has_kids
);

  cptt_pkg::cptt_cmd_t cmd;
  cptt_pkg::cptt_sts_t sts;
  logic                accept;

  // an item transfer happens when start meets an idle block
  assign accept = start && !busy;

  // sequencer: picks scan modes per op and raises the result strobe
  cptt_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (accept),
    .op        (in_op),
    .sts       (sts),
    .cmd       (cmd),
    .busy      (busy),
    .out_valid (out_valid)
  );

  // table storage, one-entry-per-cycle scan engine and result fields
  cptt_dpath u_dpath (
    .clk          (clk),
    .rst_n        (rst_n),
    .accept       (accept),
    .in_parent_id (in_parent_id),
    .in_child_id  (in_child_id),
    .in_pid       (in_pid),
    .cmd          (cmd),
    .sts          (sts),
    .add_done     (out_add_done),
    .exit_found   (out_exit_found),
    .wake_valid   (out_wake_valid),
    .wake_pid     (out_wake_pid),
    .has_kids     (out_has_kids)
  );

endmodule

`default_nettype wire

@@ sv/cptt_ctrl.sv @@
// controller that sequences the table scans of one item
`default_nettype none

module cptt_ctrl (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      accept,
  input  wire logic [cptt_pkg::OP_W-1:0] op,
  input  wire cptt_pkg::cptt_sts_t       sts,
  output cptt_pkg::cptt_cmd_t            cmd,
  output logic                           busy,
  output logic                           out_valid
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_FINISH
  } state_t;

  state_t               state_r;
  logic                 busy_r;
  logic                 out_valid_r;
  logic                 scan_start_r;
  cptt_pkg::scan_mode_t mode_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      busy_r       <= 1'b0;
      out_valid_r  <= 1'b0;
      scan_start_r <= 1'b0;
      mode_r       <= cptt_pkg::SCAN_FREE;
    end else begin
      scan_start_r <= 1'b0;
      out_valid_r  <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (accept) begin
            busy_r <= 1'b1;
            unique case (op)
              cptt_pkg::OP_ADD: begin
                mode_r       <= cptt_pkg::SCAN_FREE;
                scan_start_r <= 1'b1;
                state_r      <= S_SCAN;
              end
              cptt_pkg::OP_EXIT: begin
                mode_r       <= cptt_pkg::SCAN_CHILD;
                scan_start_r <= 1'b1;
                state_r      <= S_SCAN;
              end
              cptt_pkg::OP_QUERY: begin
                mode_r       <= cptt_pkg::SCAN_PARENT;
                scan_start_r <= 1'b1;
                state_r      <= S_SCAN;
              end
              default: state_r <= S_FINISH;
            endcase
          end
        end
        S_SCAN: begin
          if (sts.done) begin
            unique case (mode_r)
              cptt_pkg::SCAN_CHILD: begin
                if (sts.hit) begin
                  mode_r       <= cptt_pkg::SCAN_LIVEPAR;
                  scan_start_r <= 1'b1;
                end else begin
                  state_r <= S_FINISH;
                end
              end
              cptt_pkg::SCAN_LIVEPAR: begin
                if (sts.hit) begin
                  state_r <= S_FINISH;
                end else begin
                  mode_r       <= cptt_pkg::SCAN_CLEAR;
                  scan_start_r <= 1'b1;
                end
              end
              default: state_r <= S_FINISH;
            endcase
          end
        end
        S_FINISH: begin
          out_valid_r <= 1'b1;
          busy_r      <= 1'b0;
          state_r     <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign cmd.scan_start = scan_start_r;
  assign cmd.mode       = mode_r;
  assign busy           = busy_r;
  assign out_valid      = out_valid_r;

endmodule

`default_nettype wire

@@ sv/cptt_dpath.sv @@
// datapath: entry memory, live and valid bits, scan engine, result registers
`default_nettype none

module cptt_dpath (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       accept,
  input  wire logic [cptt_pkg::PID_W-1:0] in_parent_id,
  input  wire logic [cptt_pkg::PID_W-1:0] in_child_id,
  input  wire logic [cptt_pkg::PID_W-1:0] in_pid,
  input  wire cptt_pkg::cptt_cmd_t        cmd,
  output cptt_pkg::cptt_sts_t             sts,
  output logic                            add_done,
  output logic                            exit_found,
  output logic                            wake_valid,
  output logic [cptt_pkg::PID_W-1:0]      wake_pid,
  output logic                            has_kids
);

  localparam int EW = 2 * cptt_pkg::PID_W;

  // entry memory: parent in the upper half, child in the lower half
  logic [EW-1:0] mem [cptt_pkg::ENTRIES];

  logic [cptt_pkg::ENTRIES-1:0] valid_r;
  logic [cptt_pkg::ENTRIES-1:0] live_r;

  logic [cptt_pkg::IDX_W-1:0] addr_r;
  logic [cptt_pkg::IDX_W-1:0] rd_idx_r;
  logic                       active_r;
  logic                       rdv_r;
  logic [EW-1:0]              rd_ent_r;
  logic                       rd_valid_r;
  logic                       rd_live_r;

  logic [cptt_pkg::PID_W-1:0] par_r;
  logic [cptt_pkg::PID_W-1:0] chi_r;
  logic [cptt_pkg::PID_W-1:0] pid_r;
  logic [cptt_pkg::PID_W-1:0] father_r;

  logic                       add_done_r;
  logic                       exit_found_r;
  logic                       wake_valid_r;
  logic [cptt_pkg::PID_W-1:0] wake_pid_r;
  logic                       has_kids_r;

  logic [cptt_pkg::PID_W-1:0] ent_par;
  logic [cptt_pkg::PID_W-1:0] ent_chi;
  logic                       cond;
  logic                       match;
  logic                       done;
  logic                       is_clear;

  // an entry that was never written or was cleared reads as zero
  assign ent_par = rd_valid_r ? rd_ent_r[EW-1:cptt_pkg::PID_W] : '0;
  assign ent_chi = rd_valid_r ? rd_ent_r[cptt_pkg::PID_W-1:0] : '0;

  always_comb begin
    case (cmd.mode)
      cptt_pkg::SCAN_FREE:    cond = !rd_live_r;
      cptt_pkg::SCAN_CHILD:   cond = rd_live_r && (ent_chi == pid_r);
      cptt_pkg::SCAN_LIVEPAR: cond = rd_live_r && (ent_par == father_r);
      cptt_pkg::SCAN_PARENT:  cond = (ent_par == pid_r);
      cptt_pkg::SCAN_CLEAR:   cond = (ent_par == father_r);
      default:                cond = 1'b0;
    endcase
  end

  assign is_clear = (cmd.mode == cptt_pkg::SCAN_CLEAR);
  assign match    = rdv_r && cond;
  assign done     = rdv_r && ((match && !is_clear) || (rd_idx_r == cptt_pkg::LAST_IDX));

  assign sts.done = done;
  assign sts.hit  = match;

  // memory port and read pipeline
  always_ff @(posedge clk) begin
    rd_ent_r   <= mem[addr_r];
    rd_valid_r <= valid_r[addr_r];
    rd_live_r  <= live_r[addr_r];
    rd_idx_r   <= addr_r;
    if (done && match && (cmd.mode == cptt_pkg::SCAN_FREE)) begin
      mem[rd_idx_r] <= {par_r, chi_r};
    end
  end

  // scan control, entry marks, result registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r     <= 1'b0;
      rdv_r        <= 1'b0;
      addr_r       <= '0;
      valid_r      <= '0;
      live_r       <= '0;
      add_done_r   <= 1'b0;
      exit_found_r <= 1'b0;
      wake_valid_r <= 1'b0;
      wake_pid_r   <= '0;
      has_kids_r   <= 1'b0;
    end else begin
      if (cmd.scan_start) begin
        addr_r   <= '0;
        active_r <= 1'b1;
        rdv_r    <= 1'b0;
      end else begin
        rdv_r    <= active_r && !done;
        active_r <= active_r && !done && (addr_r != cptt_pkg::LAST_IDX);
        if (active_r) begin
          addr_r <= addr_r + 1'b1;
        end
      end

      if (accept) begin
        add_done_r   <= 1'b0;
        exit_found_r <= 1'b0;
        wake_valid_r <= 1'b0;
        wake_pid_r   <= '0;
        has_kids_r   <= 1'b0;
      end

      if (match) begin
        case (cmd.mode)
          cptt_pkg::SCAN_FREE: begin
            valid_r[rd_idx_r] <= 1'b1;
            live_r[rd_idx_r]  <= 1'b1;
            add_done_r        <= 1'b1;
          end
          cptt_pkg::SCAN_CHILD: begin
            live_r[rd_idx_r] <= 1'b0;
            exit_found_r     <= 1'b1;
          end
          cptt_pkg::SCAN_PARENT: has_kids_r <= 1'b1;
          cptt_pkg::SCAN_CLEAR: begin
            valid_r[rd_idx_r] <= 1'b0;
            live_r[rd_idx_r]  <= 1'b0;
          end
          default: ;
        endcase
      end

      // parent has no live child left: wake it
      if (done && !match && (cmd.mode == cptt_pkg::SCAN_LIVEPAR)) begin
        wake_valid_r <= 1'b1;
        wake_pid_r   <= father_r;
      end
    end
  end

  // captured item fields
  always_ff @(posedge clk) begin
    if (accept) begin
      par_r <= in_parent_id;
      chi_r <= in_child_id;
      pid_r <= in_pid;
    end
    if (match && (cmd.mode == cptt_pkg::SCAN_CHILD)) begin
      father_r <= ent_par;
    end
  end

  assign add_done   = add_done_r;
  assign exit_found = exit_found_r;
  assign wake_valid = wake_valid_r;
  assign wake_pid   = wake_pid_r;
  assign has_kids   = has_kids_r;

endmodule

`default_nettype wire

@@ sv/cptt_checker.sv @@
// port-level checker of the child process tracking table and its bind
`default_nettype none

module cptt_checker (
  input wire logic                       clk,
  input wire logic                       rst_n,
  input wire logic                       start,
  input wire logic                       busy,
  input wire logic                       out_valid,
  input wire logic                       out_add_done,
  input wire logic                       out_exit_found,
  input wire logic                       out_wake_valid,
  input wire logic [cptt_pkg::PID_W-1:0] out_wake_pid,
  input wire logic                       out_has_kids
);

  // an accepted item keeps the block busy
  a_busy_after_start: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("busy not raised after transfer");

  // the strobe ends the item: block is idle while it shows
  a_idle_at_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result shown while busy");

  // at most one op's flag group is set in a result
  a_one_op: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $onehot0({out_add_done, out_exit_found, out_has_kids}))
    else $error("flags of several ops set");

  // a wake only follows a found exit
  a_wake_needs_exit: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_wake_valid) |-> out_exit_found)
    else $error("wake without exit");

  // no wake means zero wake pid
  a_wake_pid_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_wake_valid) |-> (out_wake_pid == '0))
    else $error("wake pid not zero");

endmodule

bind child_process_tracking_table_core cptt_checker u_cptt_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .start          (start),
  .busy           (busy),
  .out_valid      (out_valid),
  .out_add_done   (out_add_done),
  .out_exit_found (out_exit_found),
  .out_wake_valid (out_wake_valid),
  .out_wake_pid   (out_wake_pid),
  .out_has_kids   (out_has_kids)
);

`default_nettype wire
